[hdl/mpi_pkg.sv]
// ----------------------------------------------------------------------------
// Modular power and inverse package
// Shared constants, state encoding and multiplier request/response types.
// ----------------------------------------------------------------------------
package mpi_pkg;

    localparam int EXP_BITS_DEFAULT = 63;
    localparam int EXP_W            = 63;
    localparam int RES_W            = 30;

    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    localparam logic [RES_W-1:0] PRIME_MOD    = 30'd998244353;
    localparam logic [RES_W-1:0] INV_EXPONENT = PRIME_MOD - 30'd2;
    localparam logic [30:0]      BARRETT_MU   = 31'((61'd1 << 60) / 61'(PRIME_MOD));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_SQUARE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] a;
        logic [RES_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] product;
    } mul_rsp_t;

endpackage

[hdl/mpi_modmul.sv]
// ----------------------------------------------------------------------------
// Modular multiplier
// Four-stage Barrett multiplier modulo the prime, shared by the sequencer.
// ----------------------------------------------------------------------------
module mpi_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  mpi_pkg::mul_req_t req,
    output mpi_pkg::mul_rsp_t rsp
);

    logic [3:0]  valid_reg;
    logic [59:0] prod_reg;
    logic [31:0] low_reg;
    logic [30:0] quot_reg;
    logic [31:0] rem_reg;
    logic [29:0] out_reg;

    logic [61:0] est_full;
    logic [31:0] qp_low;
    logic [31:0] rem_fixed;
    logic [31:0] prime_w;
    logic [31:0] twice_prime;

    assign prime_w     = 32'(mpi_pkg::PRIME_MOD);
    assign twice_prime = prime_w << 1;
    assign est_full    = 62'(prod_reg[59:29]) * 62'(mpi_pkg::BARRETT_MU);
    assign qp_low      = 32'(quot_reg) * prime_w;

    always_comb
    begin
        if (rem_reg >= twice_prime)
        begin
            rem_fixed = rem_reg - twice_prime;
        end
        else if (rem_reg >= prime_w)
        begin
            rem_fixed = rem_reg - prime_w;
        end
        else
        begin
            rem_fixed = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 60'(req.a) * 60'(req.b);
        low_reg  <= prod_reg[31:0];
        quot_reg <= est_full[61:31];
        rem_reg  <= low_reg - qp_low;
        out_reg  <= rem_fixed[29:0];
    end

    assign rsp.done    = valid_reg[3];
    assign rsp.product = out_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> ##4 rsp.done)
        else $error("modmul: result not delivered four cycles after start");

    a_product_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (rsp.product < mpi_pkg::PRIME_MOD))
        else $error("modmul: product not reduced below the modulus");

endmodule

[hdl/modular_power_and_inverse_unit.sv]
// Per exponent bit up to the highest set bit, a clear bit takes a square and a set bit
// a multiply into the accumulator, then a square; the highest set bit takes only the
// multiply. One transfer at a time; the next input can be accepted in the cycle after
// the result enters the output register. Each multiply and square waits on the shared
// four-stage multiplier.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Modular power and inverse unit
// Square-and-multiply modulo 998244353 with a Fermat inverse mode.
// ----------------------------------------------------------------------------
module modular_power_and_inverse_unit #(
    parameter int EXP_BITS = mpi_pkg::EXP_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [29:0]                 base,
    input  logic [mpi_pkg::EXP_W-1:0]   exponent,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [29:0]                 result
);

    mpi_pkg::state_t   state_reg, state_next;
    mpi_pkg::mul_req_t mul_req;
    mpi_pkg::mul_rsp_t mul_rsp;

    logic                out_valid_reg, out_valid_next;
    logic [29:0]         result_reg, result_next;
    logic [29:0]         acc_reg, acc_next;
    logic [29:0]         sq_reg, sq_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;

    logic [EXP_BITS-1:0] exp_rest;
    logic [EXP_BITS-1:0] exp_load;
    logic [63:0]         exp_full;
    logic [29:0]         base_red;
    logic                in_xfer;
    logic                slot_free;
    logic                finish;

    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign exp_rest  = exp_reg >> 1;
    assign exp_full  = (operation == mpi_pkg::OP_INVERSE) ?
                       64'(mpi_pkg::INV_EXPONENT) : {1'b0, exponent};
    assign exp_load  = exp_full[EXP_BITS-1:0];
    assign base_red  = (base >= mpi_pkg::PRIME_MOD) ? (base - mpi_pkg::PRIME_MOD) : base;

    mpi_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mpi_pkg::ST_CHECK;
                end
            end
            mpi_pkg::ST_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    if (slot_free)
                    begin
                        state_next = mpi_pkg::ST_IDLE;
                    end
                end
                else if (exp_reg[0])
                begin
                    state_next = mpi_pkg::ST_MUL_ACC;
                end
                else
                begin
                    state_next = mpi_pkg::ST_SQUARE;
                end
            end
            mpi_pkg::ST_MUL_ACC:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (exp_rest == '0) ? mpi_pkg::ST_CHECK : mpi_pkg::ST_SQUARE;
                end
            end
            mpi_pkg::ST_SQUARE:
            begin
                if (mul_rsp.done)
                begin
                    state_next = mpi_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = mpi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        finish        = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = sq_reg;
        mul_req.b     = sq_reg;
        case (state_reg)
            mpi_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            mpi_pkg::ST_CHECK:
            begin
                finish        = (exp_reg == '0) && slot_free;
                mul_req.start = (exp_reg != '0);
                if (exp_reg[0])
                begin
                    mul_req.a = acc_reg;
                end
            end
            mpi_pkg::ST_MUL_ACC:
            begin
                mul_req.start = mul_rsp.done && (exp_rest != '0);
            end
            mpi_pkg::ST_SQUARE:
            begin
                mul_req.start = 1'b0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_xfer)
        begin
            acc_next = 30'd1;
            sq_next  = base_red;
            exp_next = exp_load;
        end
        if ((state_reg == mpi_pkg::ST_MUL_ACC) && mul_rsp.done)
        begin
            acc_next = mul_rsp.product;
            if (exp_rest == '0)
            begin
                exp_next = '0;
            end
        end
        if ((state_reg == mpi_pkg::ST_SQUARE) && mul_rsp.done)
        begin
            sq_next  = mul_rsp.product;
            exp_next = exp_rest;
        end
        if (finish)
        begin
            result_next    = acc_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == mpi_pkg::ST_CHECK))
        else $error("top: accepted transfer did not start the sequence");

    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mpi_pkg::ST_IDLE) |->
            ((acc_reg < mpi_pkg::PRIME_MOD) && (sq_reg < mpi_pkg::PRIME_MOD)))
        else $error("top: working operands not reduced");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |->
            ((state_reg == mpi_pkg::ST_MUL_ACC) || (state_reg == mpi_pkg::ST_SQUARE)))
        else $error("top: multiplier result arrived outside a wait state");

    a_result_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == mpi_pkg::ST_CHECK))
        else $error("top: result presented without finishing a sequence");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular power and inverse unit testbench
// A driver and a monitor exchange transfers with the unit under random idle
// and stall patterns. Each accepted input is predicted by a square-and-multiply
// model modulo 998244353, and every result is compared in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 9;
    localparam int          EXP_BITS      = mpi_pkg::EXP_BITS_DEFAULT;
    localparam int          RANDOM_COUNT  = 1728;
    localparam int          DRAIN_INDEX   = 900;
    localparam int          QUIET_FIRST   = 800;
    localparam int          QUIET_LAST    = 1100;
    localparam int          IDLE_PERCENT  = 18;
    localparam int          SETTLE_CYCLES = 600;
    localparam int          CYCLE_LIMIT   = 6_000_000;
    localparam int          PRINT_LIMIT   = 50;
    localparam logic [29:0] BASE_MAX      = 30'h3FFF_FFFF;
    localparam logic [62:0] EXP_MAX       = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic                      op;
        logic [29:0]               base;
        logic [mpi_pkg::EXP_W-1:0] exponent;
        bit                        drain_first;
    } pow_request_t;

    typedef struct {
        pow_request_t req;
        logic [29:0]  value;
    } residue_entry_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic                      operation = mpi_pkg::OP_POWER;
    logic [29:0]               base      = '0;
    logic [mpi_pkg::EXP_W-1:0] exponent  = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [29:0]               result;

    pow_request_t   request_queue[$];
    residue_entry_t residue_queue[$];
    int             error_count    = 0;
    int             sent_count     = 0;
    int             received_count = 0;
    int             cycle_count    = 0;

    modular_power_and_inverse_unit #(
        .EXP_BITS (EXP_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [29:0] predict_mod_power(logic op, logic [29:0] b,
                                                      logic [mpi_pkg::EXP_W-1:0] e);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned eff;
        longint unsigned modulus;
        eff     = (op == mpi_pkg::OP_INVERSE) ? 64'(mpi_pkg::INV_EXPONENT) : 64'(e);
        modulus = 64'(mpi_pkg::PRIME_MOD);
        acc     = 1;
        sq      = 64'(b) % modulus;
        for (int i = 0; i < EXP_BITS && i < 64; i++)
        begin
            if (eff[i])
                acc = (acc * sq) % modulus;
            sq = (sq * sq) % modulus;
        end
        return acc[29:0];
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_request(logic op, logic [29:0] b, logic [mpi_pkg::EXP_W-1:0] e,
                               bit drain);
        pow_request_t req;
        req.op          = op;
        req.base        = b;
        req.exponent    = e;
        req.drain_first = drain;
        request_queue.push_back(req);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        pow_request_t   next_req;
        residue_entry_t entry;
        bit             take_next;
        bit             quiet;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= mpi_pkg::OP_POWER;
            base      <= '0;
            exponent  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                entry.req.op          = operation;
                entry.req.base        = base;
                entry.req.exponent    = exponent;
                entry.req.drain_first = 1'b0;
                entry.value           = predict_mod_power(operation, base, exponent);
                residue_queue.push_back(entry);
                sent_count++;
            end
            if (!in_valid || !in_stall)
            begin
                take_next = 1'b0;
                quiet     = (sent_count >= QUIET_FIRST) && (sent_count < QUIET_LAST);
                if (request_queue.size() != 0)
                begin
                    if (request_queue[0].drain_first && residue_queue.size() != 0)
                        take_next = 1'b0;
                    else if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
                        take_next = 1'b0;
                    else
                        take_next = 1'b1;
                end
                if (take_next)
                begin
                    next_req  = request_queue.pop_front();
                    in_valid  <= 1'b1;
                    operation <= next_req.op;
                    base      <= next_req.base;
                    exponent  <= next_req.exponent;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        residue_entry_t want;
        bit             quiet;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (residue_queue.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with no transfer pending", result));
                end
                else
                begin
                    want = residue_queue.pop_front();
                    if (result !== want.value)
                        report_mismatch($sformatf(
                            "op=%0d base=%0d exponent=%0d result %0d, predicted %0d",
                            want.req.op, want.req.base, want.req.exponent, result,
                            want.value));
                end
                received_count++;
            end
            quiet = (received_count >= QUIET_FIRST) && (received_count < QUIET_LAST);
            if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [29:0] corner_bases[6];
        logic [63:0] raw;
        logic [29:0] b;
        logic        op;
        int          roll;
        int          width;

        corner_bases = '{30'd0, mpi_pkg::PRIME_MOD, mpi_pkg::PRIME_MOD - 30'd1, 30'd1,
                         BASE_MAX, mpi_pkg::PRIME_MOD + 30'd1};

        // Zero exponents, including bases that reduce to zero, then further power corner cases.
        add_request(mpi_pkg::OP_POWER, 30'd0, 63'd0, 1'b0);
        add_request(mpi_pkg::OP_POWER, mpi_pkg::PRIME_MOD, 63'd0, 1'b0);
        add_request(mpi_pkg::OP_POWER, BASE_MAX, 63'd0, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd0, 63'd1, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd0, EXP_MAX, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd1, EXP_MAX, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd2, 63'd1, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd2, 63'd10, 1'b0);
        add_request(mpi_pkg::OP_POWER, mpi_pkg::PRIME_MOD - 30'd1, 63'd1, 1'b0);
        add_request(mpi_pkg::OP_POWER, mpi_pkg::PRIME_MOD - 30'd1, 63'd2, 1'b0);
        add_request(mpi_pkg::OP_POWER, mpi_pkg::PRIME_MOD + 30'd1, EXP_MAX, 1'b0);
        add_request(mpi_pkg::OP_POWER, BASE_MAX, EXP_MAX, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd3, 63'(mpi_pkg::PRIME_MOD - 30'd1), 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'd12345, 63'd1 << 62, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'h1555_5555, 63'h5555_5555_5555_5555, 1'b0);
        add_request(mpi_pkg::OP_POWER, 30'h2AAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
        // The inverse of zero is zero; the exponent port is ignored here.
        add_request(mpi_pkg::OP_INVERSE, 30'd0, 63'd0, 1'b0);
        add_request(mpi_pkg::OP_INVERSE, mpi_pkg::PRIME_MOD, EXP_MAX, 1'b0);
        add_request(mpi_pkg::OP_INVERSE, 30'd1, 63'd0, 1'b0);
        add_request(mpi_pkg::OP_INVERSE, 30'd2, 63'd5, 1'b0);
        add_request(mpi_pkg::OP_INVERSE, mpi_pkg::PRIME_MOD - 30'd1, 63'd0, 1'b0);
        add_request(mpi_pkg::OP_INVERSE, BASE_MAX, EXP_MAX, 1'b0);
        add_request(mpi_pkg::OP_INVERSE, mpi_pkg::PRIME_MOD + 30'd1,
                    63'h1234_5678_9ABC_DEF0, 1'b0);

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            op   = ($urandom_range(0, 99) < 25) ? mpi_pkg::OP_INVERSE : mpi_pkg::OP_POWER;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                b = corner_bases[$urandom_range(0, 5)];
            else if (roll < 20)
                b = mpi_pkg::PRIME_MOD +
                    30'($urandom_range(0, BASE_MAX - mpi_pkg::PRIME_MOD));
            else
                b = 30'($urandom);
            raw  = {$urandom, $urandom};
            roll = $urandom_range(0, 99);
            if (roll < 3)
                width = 0;
            else if (roll < 45)
                width = $urandom_range(1, 12);
            else if (roll < 75)
                width = $urandom_range(13, 40);
            else
                width = mpi_pkg::EXP_W;
            raw = raw & ((64'd1 << width) - 64'd1);
            add_request(op, b, raw[mpi_pkg::EXP_W-1:0], (n == 0) || (n == DRAIN_INDEX));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (residue_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
hdl/mpi_pkg.sv
hdl/mpi_modmul.sv
hdl/modular_power_and_inverse_unit.sv
bench/tb_top.sv
